[sv/dat_pkg.sv]
// shared types, codes and constants for the duplicate address table
package dat_pkg;

    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int MARK_W     = 2;
    localparam int CNT_OUT_W  = 5;
    localparam int IDX_IN_W   = 5;
    localparam int WANT_W     = 6;
    localparam int DEPTH_DEF  = 32;
    localparam int MAX_RUN    = 32;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 64;

    // command codes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // duplicate marks
    localparam logic [MARK_W-1:0] MARK_UNIQUE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_IP     = 2'd1;
    localparam logic [MARK_W-1:0] MARK_MAC    = 2'd2;
    localparam logic [MARK_W-1:0] MARK_BOTH   = 2'd3;

    // result status
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;

    // register select, taken from paddr bit 3
    localparam logic REG_LOCAL_IP  = 1'b0;
    localparam logic REG_LOCAL_MAC = 1'b1;

    typedef struct packed {
        logic [1:0]          mode;
        logic [IP_W-1:0]     node_ip;
        logic [MAC_W-1:0]    node_mac;
        logic [IDX_IN_W-1:0] start_index;
        logic [WANT_W-1:0]   read_count;
    } t_in_item;

    typedef struct packed {
        logic                 status;
        logic [MARK_W-1:0]    mark;
        logic                 stored;
        logic [IP_W-1:0]      entry_ip;
        logic [MAC_W-1:0]     entry_mac;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 last;
    } t_out_item;

    // table port controls from the sequencer
    typedef struct packed {
        logic wr_entry;
        logic wr_mark;
        logic rd;
    } t_ram_ctl;

endpackage

[sv/dat_ram.sv]
// entry table storage: address/MAC array and mark array on one address port
module dat_ram #(
    parameter int TABLE_DEPTH = dat_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  dat_pkg::t_ram_ctl                i_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   i_addr,
    input  logic [dat_pkg::IP_W-1:0]         i_wr_ip,
    input  logic [dat_pkg::MAC_W-1:0]        i_wr_mac,
    input  logic [dat_pkg::MARK_W-1:0]       i_wr_mark,
    output logic [dat_pkg::IP_W-1:0]         o_rd_ip,
    output logic [dat_pkg::MAC_W-1:0]        o_rd_mac,
    output logic [dat_pkg::MARK_W-1:0]       o_rd_mark
);
    import dat_pkg::*;

    logic [IP_W+MAC_W-1:0] r_ent_mem  [TABLE_DEPTH];
    logic [MARK_W-1:0]     r_mark_mem [TABLE_DEPTH];
    logic [IP_W+MAC_W-1:0] r_rd_ent;
    logic [MARK_W-1:0]     r_rd_mark;

    // address and mac words
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_entry) begin
            r_ent_mem[i_addr] <= {i_wr_mac, i_wr_ip};
        end
        if (i_ctl.rd) begin
            r_rd_ent <= r_ent_mem[i_addr];
        end
    end

    // duplicate marks, written alone when an older entry is marked
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_mark) begin
            r_mark_mem[i_addr] <= i_wr_mark;
        end
        if (i_ctl.rd) begin
            r_rd_mark <= r_mark_mem[i_addr];
        end
    end

    assign o_rd_ip   = r_rd_ent[IP_W-1:0];
    assign o_rd_mac  = r_rd_ent[IP_W+MAC_W-1:IP_W];
    assign o_rd_mark = r_rd_mark;

endmodule

[sv/dat_ctrl.sv]
// command sequencer with the shared entry compare and the result register
module dat_ctrl #(
    parameter int TABLE_DEPTH = dat_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  dat_pkg::t_in_item                i_in_item,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output dat_pkg::t_out_item               o_out_item,
    input  logic                             i_out_stall,
    input  logic [dat_pkg::IP_W-1:0]         i_local_ip,
    input  logic [dat_pkg::MAC_W-1:0]        i_local_mac,
    output dat_pkg::t_ram_ctl                o_ram_ctl,
    output logic [$clog2(TABLE_DEPTH)-1:0]   o_ram_addr,
    output logic [dat_pkg::IP_W-1:0]         o_ram_ip,
    output logic [dat_pkg::MAC_W-1:0]        o_ram_mac,
    output logic [dat_pkg::MARK_W-1:0]       o_ram_mark,
    input  logic [dat_pkg::IP_W-1:0]         i_rd_ip,
    input  logic [dat_pkg::MAC_W-1:0]        i_rd_mac,
    input  logic [dat_pkg::MARK_W-1:0]       i_rd_mark
);
    import dat_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH);
    localparam int XW = ((CW > WANT_W) ? CW : WANT_W) + 1;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_MARK     = 3'd2;
    localparam logic [2:0] S_STORE    = 3'd3;
    localparam logic [2:0] S_RESP     = 3'd4;
    localparam logic [2:0] S_RD_ISSUE = 3'd5;
    localparam logic [2:0] S_RD_WAIT  = 3'd6;

    // control state
    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic               r_issue_more, n_issue_more;
    logic               r_cmp_valid, n_cmp_valid;

    // payload state
    logic [IP_W-1:0]    r_node_ip, n_node_ip;
    logic [MAC_W-1:0]   r_node_mac, n_node_mac;
    logic [MARK_W-1:0]  r_mark, n_mark;
    logic               r_status, n_status;
    logic               r_stored, n_stored;
    logic [CW-1:0]      r_issue_idx, n_issue_idx;
    logic [CW-1:0]      r_cmp_idx, n_cmp_idx;
    logic [CW-1:0]      r_hit_idx, n_hit_idx;
    logic [CW-1:0]      r_addr, n_addr;
    logic [WANT_W-1:0]  r_left, n_left;
    t_out_item          r_out, n_out;

    logic               in_xfer;
    logic               out_free;
    logic               ip_eq;
    logic               mac_eq;
    logic               hit;
    logic [MARK_W-1:0]  hit_mark;
    logic [CW-1:0]      last_idx;
    logic [XW-1:0]      count_x;
    logic [XW-1:0]      start_x;
    logic [XW-1:0]      want_x;
    logic [XW-1:0]      remain_x;
    logic [XW-1:0]      run_x;
    logic [CNT_OUT_W-1:0] count_out;

    assign in_xfer   = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_idx  = r_count - CW'(1);
    assign count_out = CNT_OUT_W'(r_count);

    // shared compare unit: one stored entry against the new node per cycle
    assign ip_eq  = (i_rd_ip == r_node_ip);
    assign mac_eq = (i_rd_mac == r_node_mac);
    assign hit    = r_cmp_valid && (ip_eq || mac_eq);
    always_comb begin
        if (ip_eq && mac_eq) begin
            hit_mark = MARK_BOTH;
        end else if (ip_eq) begin
            hit_mark = MARK_IP;
        end else if (mac_eq) begin
            hit_mark = MARK_MAC;
        end else begin
            hit_mark = MARK_UNIQUE;
        end
    end

    // read run length, clipped to the entries left and to the longest run
    assign count_x  = XW'(r_count);
    assign start_x  = XW'(i_in_item.start_index);
    assign want_x   = XW'(i_in_item.read_count);
    assign remain_x = count_x - start_x;
    always_comb begin
        run_x = (want_x < remain_x) ? want_x : remain_x;
        if (run_x > XW'(MAX_RUN)) begin
            run_x = XW'(MAX_RUN);
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_issue_more = r_issue_more;
        n_cmp_valid  = r_cmp_valid;
        n_node_ip    = r_node_ip;
        n_node_mac   = r_node_mac;
        n_mark       = r_mark;
        n_status     = r_status;
        n_stored     = r_stored;
        n_issue_idx  = r_issue_idx;
        n_cmp_idx    = r_cmp_idx;
        n_hit_idx    = r_hit_idx;
        n_addr       = r_addr;
        n_left       = r_left;
        n_out        = r_out;
        o_ram_ctl    = '0;
        o_ram_addr   = r_addr;
        o_ram_ip     = r_node_ip;
        o_ram_mac    = r_node_mac;
        o_ram_mark   = r_mark;

        // result register drains on a transfer
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_mark     = MARK_UNIQUE;
                    n_status   = STAT_OK;
                    n_stored   = 1'b0;
                    n_node_ip  = i_in_item.node_ip;
                    n_node_mac = i_in_item.node_mac;
                    n_state    = S_RESP;
                    case (i_in_item.mode)
                        MODE_START: begin
                            o_ram_ctl.wr_entry = 1'b1;
                            o_ram_ctl.wr_mark  = 1'b1;
                            o_ram_addr         = '0;
                            o_ram_ip           = i_local_ip;
                            o_ram_mac          = i_local_mac;
                            o_ram_mark         = MARK_UNIQUE;
                            n_count            = CW'(1);
                        end
                        MODE_ADD: begin
                            if (r_count == '0) begin
                                n_state = S_STORE;
                            end else begin
                                n_issue_idx  = '0;
                                n_issue_more = 1'b1;
                                n_cmp_valid  = 1'b0;
                                n_state      = S_SCAN;
                            end
                        end
                        MODE_READ: begin
                            if (start_x >= count_x) begin
                                n_status = STAT_RANGE;
                            end else if (run_x != '0) begin
                                n_addr  = CW'(i_in_item.start_index);
                                n_left  = WANT_W'(run_x);
                                n_state = S_RD_ISSUE;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // one read issued and one compare done per cycle
            S_SCAN: begin
                o_ram_ctl.rd = r_issue_more;
                o_ram_addr   = r_issue_idx;
                n_cmp_valid  = r_issue_more;
                n_cmp_idx    = r_issue_idx;
                if (r_issue_more) begin
                    if (r_issue_idx == last_idx) begin
                        n_issue_more = 1'b0;
                    end else begin
                        n_issue_idx = r_issue_idx + CW'(1);
                    end
                end
                if (hit) begin
                    n_mark       = hit_mark;
                    n_hit_idx    = r_cmp_idx;
                    n_issue_more = 1'b0;
                    n_cmp_valid  = 1'b0;
                    n_state      = S_MARK;
                end else if (r_cmp_valid && (r_cmp_idx == last_idx)) begin
                    n_mark       = MARK_UNIQUE;
                    n_issue_more = 1'b0;
                    n_cmp_valid  = 1'b0;
                    n_state      = S_STORE;
                end
            end

            // mark the older entry that matched
            S_MARK: begin
                o_ram_ctl.wr_mark = 1'b1;
                o_ram_addr        = r_hit_idx;
                n_state           = (r_mark == MARK_BOTH) ? S_RESP : S_STORE;
            end

            // append the node, count wraps to one to keep entry zero
            S_STORE: begin
                o_ram_ctl.wr_entry = 1'b1;
                o_ram_ctl.wr_mark  = 1'b1;
                o_ram_addr         = r_count;
                n_stored           = 1'b1;
                if (r_count == CW'(TABLE_DEPTH - 1)) begin
                    n_count = CW'(1);
                end else begin
                    n_count = r_count + CW'(1);
                end
                n_state = S_RESP;
            end

            // single result of start, add, unused mode or refused or empty read
            S_RESP: begin
                if (out_free) begin
                    n_out.status      = r_status;
                    n_out.mark        = r_mark;
                    n_out.stored      = r_stored;
                    n_out.entry_ip    = '0;
                    n_out.entry_mac   = '0;
                    n_out.entry_count = count_out;
                    n_out.last        = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            S_RD_ISSUE: begin
                o_ram_ctl.rd = 1'b1;
                o_ram_addr   = r_addr;
                n_state      = S_RD_WAIT;
            end

            // read data holds until the result register takes it
            S_RD_WAIT: begin
                if (out_free) begin
                    n_out.status      = STAT_OK;
                    n_out.mark        = i_rd_mark;
                    n_out.stored      = 1'b0;
                    n_out.entry_ip    = i_rd_ip;
                    n_out.entry_mac   = i_rd_mac;
                    n_out.entry_count = count_out;
                    n_out.last        = (r_left == WANT_W'(1));
                    n_out_valid       = 1'b1;
                    if (r_left == WANT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr  = r_addr + CW'(1);
                        n_left  = r_left - WANT_W'(1);
                        n_state = S_RD_ISSUE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_issue_more <= 1'b0;
            r_cmp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_issue_more <= n_issue_more;
            r_cmp_valid  <= n_cmp_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_node_ip   <= n_node_ip;
        r_node_mac  <= n_node_mac;
        r_mark      <= n_mark;
        r_status    <= n_status;
        r_stored    <= n_stored;
        r_issue_idx <= n_issue_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_hit_idx   <= n_hit_idx;
        r_addr      <= n_addr;
        r_left      <= n_left;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[sv/duplicate_address_table_unit.sv]
// top level of the duplicate address table: config registers, sequencer and table
//
//  channel   direction  signals                              transfer when
//  in        input      i_in_valid, i_in_data, o_in_stall    i_in_valid & !o_in_stall
//  out       output     o_out_valid, o_out_data, i_out_stall o_out_valid & !i_out_stall
//  cfg       input      psel, penable, pwrite, paddr, ...    psel & penable & pwrite
//
//  start, unused commands and a refused or empty read load the result register directly;
//  add stores the node unless both keys match (an empty table is stored without a scan);
//  the scan stops at the first entry that matches either key, which is then marked:
//  the shared compare looks at one table entry per cycle through the registered table read
//  read returns each entry by one table read and then one result load
//  synchronous active-low reset clears the entry count; no clearing pass
//  a stalled result holds the sequencer; a new item is taken while the last
//  result still waits in the output register
module duplicate_address_table_unit #(
    parameter int TABLE_DEPTH = dat_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  dat_pkg::t_in_item             i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output dat_pkg::t_out_item            o_out_data,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dat_pkg::APB_AW-1:0]    paddr,
    input  logic [dat_pkg::APB_DW-1:0]    pwdata,
    output logic [dat_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import dat_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH);

    logic [IP_W-1:0]   r_local_ip;
    logic [MAC_W-1:0]  r_local_mac;
    logic              cfg_wr;
    logic              reg_sel;

    t_ram_ctl          ram_ctl;
    logic [CW-1:0]     ram_addr;
    logic [IP_W-1:0]   ram_ip;
    logic [MAC_W-1:0]  ram_mac;
    logic [MARK_W-1:0] ram_mark;
    logic [IP_W-1:0]   rd_ip;
    logic [MAC_W-1:0]  rd_mac;
    logic [MARK_W-1:0] rd_mark;

    // configuration port, registers on 8-byte steps
    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip  <= '0;
            r_local_mac <= '0;
        end else if (cfg_wr) begin
            if (reg_sel == REG_LOCAL_IP) begin
                r_local_ip <= pwdata[IP_W-1:0];
            end else begin
                r_local_mac <= pwdata[MAC_W-1:0];
            end
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_LOCAL_IP:  prdata = APB_DW'(r_local_ip);
            REG_LOCAL_MAC: prdata = APB_DW'(r_local_mac);
            default:       prdata = '0;
        endcase
    end

    dat_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_local_ip  (r_local_ip),
        .i_local_mac (r_local_mac),
        .o_ram_ctl   (ram_ctl),
        .o_ram_addr  (ram_addr),
        .o_ram_ip    (ram_ip),
        .o_ram_mac   (ram_mac),
        .o_ram_mark  (ram_mark),
        .i_rd_ip     (rd_ip),
        .i_rd_mac    (rd_mac),
        .i_rd_mark   (rd_mark)
    );

    dat_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_addr    (ram_addr),
        .i_wr_ip   (ram_ip),
        .i_wr_mac  (ram_mac),
        .i_wr_mark (ram_mark),
        .o_rd_ip   (rd_ip),
        .o_rd_mac  (rd_mac),
        .o_rd_mark (rd_mark)
    );

endmodule

[sv/dat_checker.sv]
// port-level checks of the duplicate address table, bound to the top level
module dat_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input dat_pkg::t_out_item o_out_data
);
    import dat_pkg::*;

    // the block is busy in the cycle after every accepted command
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after a transfer");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // a refused read is a single bare result
    a_range_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == STAT_RANGE)) |->
        (o_out_data.last && (o_out_data.mark == MARK_UNIQUE) && !o_out_data.stored))
        else $error("range error result carries data");

    // a stored result is the last of its command, with status ok and never a full duplicate mark
    a_stored_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.stored) |->
        (o_out_data.last && (o_out_data.status == STAT_OK) && (o_out_data.mark != MARK_BOTH)))
        else $error("stored flag on a non-final or fully duplicate result");

endmodule

bind duplicate_address_table_unit dat_checker u_dat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[sim/tb_duplicate_address_table_unit.sv]
// testbench for the duplicate address table: directed and random commands checked against a model
`timescale 1ns / 1ps

module tb_duplicate_address_table_unit;

    import dat_pkg::*;

    localparam int TABLE_DEPTH = DEPTH_DEF;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int PHASE_ITEMS = 64;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    // clock, reset and ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    t_in_item            i_in_data = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_item           o_out_data;
    logic                i_out_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // shadow of the table and the local address registers
    logic [IP_W-1:0]     cfg_ip = '0;
    logic [MAC_W-1:0]    cfg_mac = '0;
    logic [IP_W-1:0]     tbl_ip [TABLE_DEPTH];
    logic [MAC_W-1:0]    tbl_mac [TABLE_DEPTH];
    logic [MARK_W-1:0]   tbl_mark [TABLE_DEPTH];
    int                  tbl_count = 0;

    t_out_item           step_results[$];
    t_out_item           expected_results[$];
    t_out_item           head;
    t_dir_row            dir_rows[16];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int results_seen = 0;
    int wraps = 0;
    int mode_hits[4] = '{0, 0, 0, 0};

    duplicate_address_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_in_item mk_in(logic [1:0] mode, logic [IP_W-1:0] ip,
                                       logic [MAC_W-1:0] mac, logic [IDX_IN_W-1:0] first,
                                       logic [WANT_W-1:0] want);
        t_in_item it;
        it.mode = mode;
        it.node_ip = ip;
        it.node_mac = mac;
        it.start_index = first;
        it.read_count = want;
        return it;
    endfunction

    function automatic t_out_item mk_out(logic status, logic [MARK_W-1:0] mark, logic stored,
                                         logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                         logic [CNT_OUT_W-1:0] cnt, logic last);
        t_out_item r;
        r.status = status;
        r.mark = mark;
        r.stored = stored;
        r.entry_ip = ip;
        r.entry_mac = mac;
        r.entry_count = cnt;
        r.last = last;
        return r;
    endfunction

    // table behavior for one command, results left in step_results
    task automatic table_step(input t_in_item it);
        t_out_item r;
        int n;
        int k;
        int i;
        int hit;
        logic ip_eq;
        logic mac_eq;
        logic [MARK_W-1:0] mk;
        step_results.delete();
        r = '0;
        case (it.mode)
            MODE_START: begin
                tbl_ip[0] = cfg_ip;
                tbl_mac[0] = cfg_mac;
                tbl_mark[0] = MARK_UNIQUE;
                tbl_count = 1;
                r.last = 1'b1;
                step_results.push_back(r);
            end
            MODE_ADD: begin
                mk = MARK_UNIQUE;
                hit = -1;
                // first entry matching either key wins
                for (i = 0; i < tbl_count; i++) begin
                    if (hit < 0) begin
                        ip_eq = (tbl_ip[i] == it.node_ip);
                        mac_eq = (tbl_mac[i] == it.node_mac);
                        if (ip_eq || mac_eq) begin
                            hit = i;
                            mk = {mac_eq, ip_eq};
                        end
                    end
                end
                if (hit >= 0) tbl_mark[hit] = mk;
                if (mk != MARK_BOTH) begin
                    tbl_ip[tbl_count] = it.node_ip;
                    tbl_mac[tbl_count] = it.node_mac;
                    tbl_mark[tbl_count] = mk;
                    tbl_count++;
                    // full table wraps back, entry zero is kept
                    if (tbl_count == TABLE_DEPTH) begin
                        tbl_count = 1;
                        wraps++;
                    end
                    r.stored = 1'b1;
                end
                r.mark = mk;
                r.last = 1'b1;
                step_results.push_back(r);
            end
            MODE_READ: begin
                if (int'(it.start_index) >= tbl_count) begin
                    r.status = STAT_RANGE;
                    r.last = 1'b1;
                    step_results.push_back(r);
                end else begin
                    n = tbl_count - int'(it.start_index);
                    if (int'(it.read_count) < n) n = int'(it.read_count);
                    if (n > MAX_RUN) n = MAX_RUN;
                    if (n == 0) begin
                        r.last = 1'b1;
                        step_results.push_back(r);
                    end
                    for (k = 0; k < n; k++) begin
                        r = '0;
                        r.mark = tbl_mark[int'(it.start_index) + k];
                        r.entry_ip = tbl_ip[int'(it.start_index) + k];
                        r.entry_mac = tbl_mac[int'(it.start_index) + k];
                        r.last = (k == n - 1);
                        step_results.push_back(r);
                    end
                end
            end
            default: begin
                r.last = 1'b1;
                step_results.push_back(r);
            end
        endcase
        // entry count is taken after the command
        foreach (step_results[k]) step_results[k].entry_count = 5'(tbl_count);
    endtask

    // one input transfer; typed rows replace the predicted result
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        table_step(it);
        if (typed) begin
            step_results.delete();
            step_results.push_back(want);
        end
        foreach (step_results[k]) expected_results.push_back(step_results[k]);
        mode_hits[it.mode]++;
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic check_field(input string nm, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, nm, exp_v, act_v);
            errors++;
        end
    endtask

    // apb setup and access cycles, returns prdata from the access edge
    task automatic cfg_access(input logic wr, input logic reg_sel, input logic [63:0] val,
                              output logic [63:0] rd);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= APB_AW'({reg_sel, 3'b000});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_local(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        logic [63:0] rd;
        cfg_access(1'b1, REG_LOCAL_IP, 64'(ip), rd);
        cfg_access(1'b1, REG_LOCAL_MAC, 64'(mac), rd);
        cfg_ip = ip;
        cfg_mac = mac;
        cfg_access(1'b0, REG_LOCAL_IP, '0, rd);
        check_field("local_ip readback", 64'(ip), 64'(rd[IP_W-1:0]));
        cfg_access(1'b0, REG_LOCAL_MAC, '0, rd);
        check_field("local_mac readback", 64'(mac), 64'(rd[MAC_W-1:0]));
    endtask

    // random command, mostly adds that collide with what is in the table
    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        int e;
        it = mk_in(MODE_ADD, $urandom(), {16'($urandom()), 32'($urandom())},
                   5'($urandom()), 6'($urandom()));
        pick = $urandom_range(99);
        if (pick < 3) it.mode = MODE_START;
        else if (pick < 8) it.mode = MODE_SPARE;
        else if (pick < 38) it.mode = MODE_READ;
        if (it.mode == MODE_ADD && tbl_count > 0) begin
            e = $urandom_range(tbl_count - 1);
            pick = $urandom_range(99);
            if (pick < 25) begin
                it.node_ip = tbl_ip[e];
                it.node_mac = tbl_mac[e];
            end else if (pick < 45) begin
                it.node_ip = tbl_ip[e];
            end else if (pick < 65) begin
                it.node_mac = tbl_mac[e];
            end
        end
        if (it.mode == MODE_READ) begin
            if (tbl_count > 0 && $urandom_range(99) < 85)
                it.start_index = 5'($urandom_range(tbl_count - 1));
            if ($urandom_range(99) < 75)
                it.read_count = 6'($urandom_range(8));
        end
        return it;
    endfunction

    // result checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, o_out_data);
                errors++;
            end else begin
                head = expected_results.pop_front();
                check_field("status", 64'(head.status), 64'(o_out_data.status));
                check_field("mark", 64'(head.mark), 64'(o_out_data.mark));
                check_field("stored", 64'(head.stored), 64'(o_out_data.stored));
                check_field("entry_ip", 64'(head.entry_ip), 64'(o_out_data.entry_ip));
                check_field("entry_mac", 64'(head.entry_mac), 64'(o_out_data.entry_mac));
                check_field("entry_count", 64'(head.entry_count),
                            64'(o_out_data.entry_count));
                check_field("last", 64'(head.last), 64'(o_out_data.last));
                results_seen++;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // stimulus
    initial begin
        // rows: empty table, add before start, spare mode, start, key collisions, reads
        dir_rows[0]  = '{mk_in(MODE_READ, '0, '0, 5'd0, 6'd1), 1'b1,
                         mk_out(STAT_RANGE, MARK_UNIQUE, 1'b0, '0, '0, 5'd0, 1'b1)};
        dir_rows[1]  = '{mk_in(MODE_ADD, '0, '0, 5'd0, 6'd0), 1'b1,
                         mk_out(STAT_OK, MARK_UNIQUE, 1'b1, '0, '0, 5'd1, 1'b1)};
        dir_rows[2]  = '{mk_in(MODE_SPARE, '1, '1, 5'd31, 6'd63), 1'b1,
                         mk_out(STAT_OK, MARK_UNIQUE, 1'b0, '0, '0, 5'd1, 1'b1)};
        dir_rows[3]  = '{mk_in(MODE_START, '0, '0, 5'd0, 6'd0), 1'b1,
                         mk_out(STAT_OK, MARK_UNIQUE, 1'b0, '0, '0, 5'd1, 1'b1)};
        dir_rows[4]  = '{mk_in(MODE_READ, '0, '0, 5'd0, 6'd1), 1'b1,
                         mk_out(STAT_OK, MARK_UNIQUE, 1'b0, '1, '1, 5'd1, 1'b1)};
        dir_rows[5]  = '{mk_in(MODE_ADD, '1, '0, 5'd0, 6'd0), 1'b1,
                         mk_out(STAT_OK, MARK_IP, 1'b1, '0, '0, 5'd2, 1'b1)};
        dir_rows[6]  = '{mk_in(MODE_ADD, '0, '1, 5'd0, 6'd0), 1'b1,
                         mk_out(STAT_OK, MARK_MAC, 1'b1, '0, '0, 5'd3, 1'b1)};
        dir_rows[7]  = '{mk_in(MODE_ADD, '1, '1, 5'd0, 6'd0), 1'b1,
                         mk_out(STAT_OK, MARK_BOTH, 1'b0, '0, '0, 5'd3, 1'b1)};
        dir_rows[8]  = '{mk_in(MODE_ADD, 32'h1234_5678, '0, 5'd0, 6'd0), 1'b0, '0};
        dir_rows[9]  = '{mk_in(MODE_ADD, 32'h1, 48'h1, 5'd0, 6'd0), 1'b0, '0};
        dir_rows[10] = '{mk_in(MODE_READ, '0, '0, 5'd0, 6'd63), 1'b0, '0};
        dir_rows[11] = '{mk_in(MODE_READ, '0, '0, 5'd1, 6'd0), 1'b1,
                         mk_out(STAT_OK, MARK_UNIQUE, 1'b0, '0, '0, 5'd5, 1'b1)};
        dir_rows[12] = '{mk_in(MODE_READ, '0, '0, 5'd31, 6'd1), 1'b1,
                         mk_out(STAT_RANGE, MARK_UNIQUE, 1'b0, '0, '0, 5'd5, 1'b1)};
        dir_rows[13] = '{mk_in(MODE_READ, '0, '0, 5'd4, 6'd32), 1'b0, '0};
        dir_rows[14] = '{mk_in(MODE_ADD, '1, '0, 5'd0, 6'd0), 1'b0, '0};
        dir_rows[15] = '{mk_in(MODE_START, '0, '0, 5'd0, 6'd0), 1'b1,
                         mk_out(STAT_OK, MARK_UNIQUE, 1'b0, '0, '0, 5'd1, 1'b1)};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_local('1, '1);
        foreach (dir_rows[r]) send_item(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want);
        drain();

        // idle mixes: none, sender only, receiver only, both
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  set_local('0, '0); end
                1: begin send_idle_pct = 63; stall_pct = 0;
                         set_local($urandom(), {16'($urandom()), 32'($urandom())}); end
                2: begin send_idle_pct = 0;  stall_pct = 63; set_local('1, '0); end
                default: begin send_idle_pct = 30; stall_pct = 30;
                         set_local($urandom(), {16'($urandom()), 32'($urandom())}); end
            endcase
            send_item(mk_in(MODE_START, '0, '0, 5'd0, 6'd0), 1'b0, '0);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, '0);
            // sender holds off until the block has answered everything
            drain();
        end

        stall_pct = 0;
        drain();
        repeat (40) @(posedge i_clk);
        $display("tb: %0d commands sent (start %0d, add %0d, read %0d, spare %0d)",
                 mode_hits[0] + mode_hits[1] + mode_hits[2] + mode_hits[3],
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        $display("tb: %0d results compared, table wrapped %0d times, %0d mismatches",
                 results_seen, wraps, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
sv/dat_pkg.sv
sv/dat_ram.sv
sv/dat_ctrl.sv
sv/duplicate_address_table_unit.sv
sv/dat_checker.sv
sim/tb_duplicate_address_table_unit.sv
